@@ hdl/tcwc_pkg.sv @@
// Shared constants, types and per-axis helper functions for the texture
// coordinate wrap/clamp core. No dependencies.
package tcwc_pkg;

   // Texture memory size in bytes; offsets at or above this are flagged
   localparam int unsigned TMEM_BYTES = 4096;

   // Field widths
   localparam int unsigned COORD_W  = 16;
   localparam int unsigned RESULT_W = 32;
   localparam int unsigned LIMIT_W  = 12;
   localparam int unsigned OFFS_W   = 13;
   localparam int unsigned CSR_W    = 12;
   localparam int unsigned IDX_W    = 3;
   // Widest value after the shift step: 16 bits shifted left by at most 5
   localparam int unsigned SHIFT_W  = COORD_W + 5;

   // Shift codes above this shift left
   localparam logic [3:0] SHIFT_LEFT_MIN = 4'd10;

   // Configuration register indexes
   typedef enum logic [IDX_W-1:0] {
      CSR_SHIFT_CODES = 3'd0,
      CSR_MASK_WIDTHS = 3'd1,
      CSR_MODE_BITS   = 3'd2,
      CSR_S_LIMIT     = 3'd3,
      CSR_T_LIMIT     = 3'd4,
      CSR_TILE_BASE   = 3'd5
   } csr_index_type;

   // Bit positions inside mode_bits
   localparam int unsigned MODE_MIRROR_S = 0;
   localparam int unsigned MODE_MIRROR_T = 1;
   localparam int unsigned MODE_CLAMP_S  = 2;
   localparam int unsigned MODE_CLAMP_T  = 3;
   localparam int unsigned MODE_TEXEL32  = 4;

   // Shift step: codes above ten shift left by (~code & 7) + 1, else right by code
   function automatic logic [SHIFT_W-1:0] axis_shift(input logic [COORD_W-1:0] v,
                                                     input logic [3:0] code);
      logic [SHIFT_W-1:0] wide;
      logic [2:0]         lsh;
      wide = SHIFT_W'(v);
      lsh  = 3'(~code) + 3'd1;
      if (code > SHIFT_LEFT_MIN) begin
         return wide << lsh;
      end else begin
         return wide >> code;
      end
   endfunction

   // Mirror, mask and clamp steps on the shifted value
   function automatic logic [RESULT_W-1:0] axis_wrap(input logic [SHIFT_W-1:0] sv,
                                                     input logic [3:0] mpos,
                                                     input logic mirror,
                                                     input logic clamp,
                                                     input logic [LIMIT_W-1:0] limit);
      logic [RESULT_W-1:0] v;
      logic [RESULT_W-1:0] keep;
      v = RESULT_W'(sv);
      if (mirror && v[mpos]) begin
         v = ~v;
      end
      keep = (RESULT_W'(2) << mpos) - RESULT_W'(1);
      if (mirror && (mpos != 4'd0)) begin
         v = v & keep;
      end
      if ((clamp || (mpos == 4'd0)) && (v > RESULT_W'(limit))) begin
         v = RESULT_W'(limit);
      end
      return v;
   endfunction

endpackage

@@ hdl/texture_coord_wrap_clamp_core.sv @@
// Top level of the texture coordinate wrap/clamp core: four-stage pipeline
// plus configuration registers. Depends on tcwc_pkg.

// Takes one beat per clock: busy never rises, so a beat offered on start is
// always taken. Each beat passes the four stage registers; its result is shown
// for one cycle with rsp_valid and cannot be stalled. The stages: shift,
// mirror/mask/clamp/swap, row multiply (32 x 13 bits), then the add, byte
// scale, range check and base add. The user must write configuration via
// csr_we/csr_index/csr_wdata only while no beat is in flight (not enforced).
module texture_coord_wrap_clamp_core
   import tcwc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // request
   input  logic                start,
   output logic                busy,
   input  logic [COORD_W-1:0]  req_s_coord,
   input  logic [COORD_W-1:0]  req_t_coord,
   input  logic                req_swap_axes,
   // response
   output logic                rsp_valid,
   output logic [RESULT_W-1:0] rsp_s_result,
   output logic [RESULT_W-1:0] rsp_t_result,
   output logic [OFFS_W-1:0]   rsp_texel_offset,
   output logic                rsp_out_of_range,
   // configuration
   input  logic                csr_we,
   input  logic [IDX_W-1:0]    csr_index,
   input  logic [CSR_W-1:0]    csr_wdata
);

   // Configuration registers
   logic [7:0]         shift_codes_ff;
   logic [7:0]         mask_widths_ff;
   logic [4:0]         mode_bits_ff;
   logic [LIMIT_W-1:0] s_limit_ff;
   logic [LIMIT_W-1:0] t_limit_ff;
   logic [LIMIT_W-1:0] tile_base_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_codes_ff <= '0;
         mask_widths_ff <= '0;
         mode_bits_ff   <= '0;
         s_limit_ff     <= '0;
         t_limit_ff     <= '0;
         tile_base_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SHIFT_CODES: shift_codes_ff <= csr_wdata[7:0];
            CSR_MASK_WIDTHS: mask_widths_ff <= csr_wdata[7:0];
            CSR_MODE_BITS:   mode_bits_ff   <= csr_wdata[4:0];
            CSR_S_LIMIT:     s_limit_ff     <= csr_wdata;
            CSR_T_LIMIT:     t_limit_ff     <= csr_wdata;
            CSR_TILE_BASE:   tile_base_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   // Valid bits, one per stage
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic accept;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   // Stage 1: shift each axis
   logic [SHIFT_W-1:0] s1_s_ff, s1_t_ff, s1_s_in, s1_t_in;
   logic               s1_swap_ff;

   always_comb begin
      s1_s_in = axis_shift(req_s_coord, shift_codes_ff[3:0]);
      s1_t_in = axis_shift(req_t_coord, shift_codes_ff[7:4]);
   end

   always_ff @(posedge clock) begin
      s1_s_ff    <= s1_s_in;
      s1_t_ff    <= s1_t_in;
      s1_swap_ff <= req_swap_axes;
   end

   // Stage 2: mirror, mask, clamp, then swap
   logic [RESULT_W-1:0] s2_s_ff, s2_t_ff, s2_s_in, s2_t_in;
   logic [RESULT_W-1:0] s_wrap, t_wrap;

   always_comb begin
      s_wrap = axis_wrap(s1_s_ff, mask_widths_ff[3:0], mode_bits_ff[MODE_MIRROR_S],
                         mode_bits_ff[MODE_CLAMP_S], s_limit_ff);
      t_wrap = axis_wrap(s1_t_ff, mask_widths_ff[7:4], mode_bits_ff[MODE_MIRROR_T],
                         mode_bits_ff[MODE_CLAMP_T], t_limit_ff);
      s2_s_in = s1_swap_ff ? t_wrap : s_wrap;
      s2_t_in = s1_swap_ff ? s_wrap : t_wrap;
   end

   always_ff @(posedge clock) begin
      s2_s_ff <= s2_s_in;
      s2_t_ff <= s2_t_in;
   end

   // Stage 3: row offset T * pitch, kept to 32 bits
   logic [RESULT_W-1:0] s3_s_ff, s3_t_ff, s3_row_ff, s3_row_in;
   logic [LIMIT_W:0]    pitch;

   always_comb begin
      pitch     = {1'b0, s_limit_ff} + (LIMIT_W+1)'(1);
      s3_row_in = RESULT_W'(s2_t_ff * RESULT_W'(pitch));
   end

   always_ff @(posedge clock) begin
      s3_s_ff   <= s2_s_ff;
      s3_t_ff   <= s2_t_ff;
      s3_row_ff <= s3_row_in;
   end

   // Stage 4: texel index, byte scale, range check, base add
   logic [RESULT_W-1:0] texel_idx, byte_off;
   logic                oor_in;
   logic [OFFS_W-1:0]   offs_in;
   logic [RESULT_W-1:0] s4_s_ff, s4_t_ff;
   logic [OFFS_W-1:0]   s4_offs_ff;
   logic                s4_oor_ff;

   always_comb begin
      texel_idx = s3_s_ff + s3_row_ff;
      byte_off  = mode_bits_ff[MODE_TEXEL32] ? (texel_idx << 2) : (texel_idx << 1);
      oor_in    = byte_off >= RESULT_W'(TMEM_BYTES);
      offs_in   = oor_in ? '0 : OFFS_W'(RESULT_W'(tile_base_ff) + byte_off);
   end

   always_ff @(posedge clock) begin
      s4_s_ff    <= s3_s_ff;
      s4_t_ff    <= s3_t_ff;
      s4_offs_ff <= offs_in;
      s4_oor_ff  <= oor_in;
   end

   assign rsp_valid        = v4_ff;
   assign rsp_s_result     = s4_s_ff;
   assign rsp_t_result     = s4_t_ff;
   assign rsp_texel_offset = s4_offs_ff;
   assign rsp_out_of_range = s4_oor_ff;

endmodule

@@ hdl/tcwc_checker.sv @@
// Port-level checker for texture_coord_wrap_clamp_core and its bind.
// Depends on tcwc_pkg.
module tcwc_checker
   import tcwc_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input logic                rsp_valid,
   input logic [OFFS_W-1:0]   rsp_texel_offset,
   input logic                rsp_out_of_range
);

   // Every accepted beat comes out as a result with rsp_valid
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##4 rsp_valid)
      else $error("accepted beat gave no result four cycles later");

   // No result appears without a matching accepted beat
   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 4))
      else $error("result without a matching request");

   // Out-of-range results carry a zero offset
   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_of_range) |-> (rsp_texel_offset == '0))
      else $error("out-of-range result with nonzero offset");

   // Fully pipelined: the core never holds off a request
   a_never_busy: assert property (@(posedge clock) disable iff (reset)
      !busy)
      else $error("busy raised");

endmodule

bind texture_coord_wrap_clamp_core tcwc_checker u_tcwc_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_texel_offset (rsp_texel_offset),
   .rsp_out_of_range (rsp_out_of_range)
);
